>>> rtl/core/h263ps_pkg.sv
// ----------------------------------------------------------------------------
// h263ps_pkg - shared types and constants of the H.263 picture size parser
// Parse phase codes, result record, header offsets and the source format
// size table.
// ----------------------------------------------------------------------------
package h263ps_pkg;

	localparam int unsigned WIDTH_W  = 12;
	localparam int unsigned HEIGHT_W = 11;
	localparam int unsigned OFS_W    = 4;
	localparam int unsigned FMT_W    = 3;
	localparam int unsigned DIM_W    = 9;

	typedef enum logic [2:0] {
		PH_SEARCH = 3'b001,
		PH_HEADER = 3'b010,
		PH_DONE   = 3'b100
	} phase_t;

	typedef struct packed {
		logic                status;
		logic [WIDTH_W-1:0]  width;
		logic [HEIGHT_W-1:0] height;
	} pic_res_t;

	localparam logic STATUS_OK   = 1'b0;
	localparam logic STATUS_FAIL = 1'b1;

	// Top six bits of the byte that completes the 22-bit start code
	localparam logic [5:0] PSC_TAIL = 6'b100000;

	// Byte offsets from the start code byte at which fields complete
	localparam logic [OFS_W-1:0] OFS_FIRST = 4'd1;
	localparam logic [OFS_W-1:0] OFS_PTYPE = 4'd2;
	localparam logic [OFS_W-1:0] OFS_PLUS  = 4'd3;
	localparam logic [OFS_W-1:0] OFS_PWI   = 4'd8;
	localparam logic [OFS_W-1:0] OFS_PHI   = 4'd9;

	localparam logic [FMT_W-1:0] FMT_FORBIDDEN = 3'd0;
	localparam logic [FMT_W-1:0] FMT_SQCIF     = 3'd1;
	localparam logic [FMT_W-1:0] FMT_QCIF      = 3'd2;
	localparam logic [FMT_W-1:0] FMT_CIF       = 3'd3;
	localparam logic [FMT_W-1:0] FMT_4CIF      = 3'd4;
	localparam logic [FMT_W-1:0] FMT_16CIF     = 3'd5;
	localparam logic [FMT_W-1:0] FMT_CUSTOM    = 3'd6;
	localparam logic [FMT_W-1:0] FMT_EXTENDED  = 3'd7;

	localparam logic [2:0] UFEP_FULL = 3'd1;

	localparam pic_res_t RES_FAIL = '{status: STATUS_FAIL, width: '0, height: '0};

	function automatic pic_res_t std_size(input logic [FMT_W-1:0] fmt);
		pic_res_t r;
		r = '{status: STATUS_OK, width: '0, height: '0};
		unique case (fmt)
			FMT_FORBIDDEN: r = '{status: STATUS_OK, width: 12'd0,    height: 11'd0};
			FMT_SQCIF:     r = '{status: STATUS_OK, width: 12'd128,  height: 11'd96};
			FMT_QCIF:      r = '{status: STATUS_OK, width: 12'd176,  height: 11'd144};
			FMT_CIF:       r = '{status: STATUS_OK, width: 12'd352,  height: 11'd288};
			FMT_4CIF:      r = '{status: STATUS_OK, width: 12'd704,  height: 11'd576};
			FMT_16CIF:     r = '{status: STATUS_OK, width: 12'd1408, height: 11'd1152};
			default:       r = RES_FAIL;
		endcase
		return r;
	endfunction

endpackage

>>> rtl/core/h263ps_step.sv
// ----------------------------------------------------------------------------
// h263ps_step - per-byte header parser
// Holds the parse state and decides, for one byte, whether a size result
// is due; state moves on only when go is high.
// ----------------------------------------------------------------------------
module h263ps_step (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 go,
	input  logic [7:0]           data_byte,
	input  logic                 last_byte,
	output logic                 emit,
	output h263ps_pkg::pic_res_t res
);

	h263ps_pkg::phase_t                  phase_q, phase_d;
	logic [1:0]                          zrun_q, zrun_d;
	logic [h263ps_pkg::OFS_W-1:0]        ofs_q, ofs_d;
	logic [7:0]                          prev_q, prev_d;
	logic [h263ps_pkg::DIM_W-1:0]        pwi_q, pwi_d;

	logic                                dec;
	h263ps_pkg::pic_res_t                dec_res;
	logic [h263ps_pkg::FMT_W-1:0]        fmt;
	logic [2:0]                          ufep;
	logic [h263ps_pkg::DIM_W-1:0]        phi;
	logic [h263ps_pkg::DIM_W:0]          pwi_p1;

	always_comb begin
		phase_d = phase_q;
		zrun_d  = zrun_q;
		ofs_d   = ofs_q;
		prev_d  = prev_q;
		pwi_d   = pwi_q;
		dec     = 1'b0;
		dec_res = h263ps_pkg::RES_FAIL;
		fmt     = '0;
		ufep    = '0;
		phi     = '0;
		pwi_p1  = {1'b0, pwi_q} + {{h263ps_pkg::DIM_W{1'b0}}, 1'b1};
		unique case (phase_q)
			h263ps_pkg::PH_SEARCH: begin
				// two zero bytes then 100000xx: byte-aligned start code
				if (zrun_q == 2'd2 && data_byte[7:2] == h263ps_pkg::PSC_TAIL) begin
					phase_d = h263ps_pkg::PH_HEADER;
					ofs_d   = h263ps_pkg::OFS_FIRST;
				end
				if (data_byte == 8'd0)
					zrun_d = (zrun_q == 2'd2) ? zrun_q : zrun_q + 2'd1;
				else
					zrun_d = 2'd0;
			end
			h263ps_pkg::PH_HEADER: begin
				ofs_d  = ofs_q + {{(h263ps_pkg::OFS_W-1){1'b0}}, 1'b1};
				prev_d = data_byte;
				case (ofs_q)
					h263ps_pkg::OFS_PTYPE: begin
						fmt = data_byte[4:2];
						if (fmt != h263ps_pkg::FMT_CUSTOM &&
						    fmt != h263ps_pkg::FMT_EXTENDED) begin
							dec     = 1'b1;
							dec_res = h263ps_pkg::std_size(fmt);
						end
					end
					h263ps_pkg::OFS_PLUS: begin
						ufep = {prev_q[1:0], data_byte[7]};
						fmt  = data_byte[6:4];
						if (ufep != h263ps_pkg::UFEP_FULL) begin
							dec = 1'b1;
						end else if (fmt == h263ps_pkg::FMT_EXTENDED) begin
							dec = 1'b1;    // reserved OPPTYPE format
						end else if (fmt != h263ps_pkg::FMT_CUSTOM) begin
							dec     = 1'b1;
							dec_res = h263ps_pkg::std_size(fmt);
						end
					end
					h263ps_pkg::OFS_PWI: begin
						pwi_d = {prev_q[6:0], data_byte[7:6]};
					end
					h263ps_pkg::OFS_PHI: begin
						phi     = {prev_q[4:0], data_byte[7:4]};
						dec     = 1'b1;
						dec_res = '{status: h263ps_pkg::STATUS_OK,
						            width:  {pwi_p1, 2'b00},
						            height: {phi, 2'b00}};
					end
					default: ;
				endcase
				if (dec)
					phase_d = h263ps_pkg::PH_DONE;
			end
			h263ps_pkg::PH_DONE: ;
			default: ;
		endcase
		if (last_byte) begin
			phase_d = h263ps_pkg::PH_SEARCH;
			zrun_d  = 2'd0;
			ofs_d   = '0;
			pwi_d   = '0;
		end
	end

	// last byte with nothing decided yet gives a failure
	assign emit = dec || (last_byte && phase_q != h263ps_pkg::PH_DONE);
	assign res  = dec ? dec_res : h263ps_pkg::RES_FAIL;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= h263ps_pkg::PH_SEARCH;
			zrun_q  <= 2'd0;
			ofs_q   <= '0;
			pwi_q   <= '0;
		end else if (go) begin
			phase_q <= phase_d;
			zrun_q  <= zrun_d;
			ofs_q   <= ofs_d;
			pwi_q   <= pwi_d;
		end
	end

	always_ff @(posedge clk) begin
		if (go)
			prev_q <= prev_d;
	end

`ifndef SYNTH
	a_last_rearms: assert property (@(posedge clk) disable iff (!arst_n)
		go && last_byte |=> phase_q == h263ps_pkg::PH_SEARCH)
		else $error("parser not back to search after last byte");

	a_done_silent: assert property (@(posedge clk) disable iff (!arst_n)
		phase_q == h263ps_pkg::PH_DONE && !last_byte |-> !emit)
		else $error("second result within one buffer");

	a_header_range: assert property (@(posedge clk) disable iff (!arst_n)
		phase_q == h263ps_pkg::PH_HEADER |-> ofs_q >= h263ps_pkg::OFS_FIRST &&
		ofs_q <= h263ps_pkg::OFS_PHI)
		else $error("header byte offset beyond last field");
`endif

endmodule

>>> rtl/core/h263_picture_size_parser_unit.sv
// ----------------------------------------------------------------------------
// h263_picture_size_parser_unit - H.263 picture size parser
// Finds the byte-aligned picture start code in a byte stream and reports the
// picture size from PTYPE, PLUSPTYPE and CPFMT, one result per buffer.
// ----------------------------------------------------------------------------
//
//   channel | handshake            | payload
//   --------+----------------------+------------------------------
//   input   | in_valid / in_ready  | data_byte[7:0], last_byte
//   output  | out_valid / out_ready| status, width[11:0], height[10:0]
//
// Cycles: one byte per cycle while the input register is not held (see Stalls);
//   a deciding byte passes through the input register, then its result is
//   loaded into the result register and presented from there. The per-byte
//   parse is a fixed-offset field extract after the start code byte, so no
//   byte needs more than one pass.
// Reset: arst_n clears the valid flags and the parse state to start code
//   search; payload registers are not reset.
// Stalls: the input register holds while a result is due and the result
//   register is still full; bytes that produce no result keep flowing.
//
module h263_picture_size_parser_unit (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              in_valid,
	output logic                              in_ready,
	input  logic [7:0]                        data_byte,
	input  logic                              last_byte,
	output logic                              out_valid,
	input  logic                              out_ready,
	output logic                              status,
	output logic [h263ps_pkg::WIDTH_W-1:0]    width,
	output logic [h263ps_pkg::HEIGHT_W-1:0]   height
);

	// input register
	logic                 valid_s1;
	logic [7:0]           byte_s1;
	logic                 last_s1;

	// result register
	logic                 out_valid_q;
	h263ps_pkg::pic_res_t res_q;

	logic                 step_emit;
	h263ps_pkg::pic_res_t step_res;
	logic                 out_free;
	logic                 go_s1;

	// result register can take a new result when empty or being drained
	assign out_free = !out_valid_q || out_ready;
	// a byte that yields no result never waits on the output side
	assign go_s1    = valid_s1 && (!step_emit || out_free);
	assign in_ready = !valid_s1 || go_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			byte_s1 <= data_byte;
			last_s1 <= last_byte;
		end
	end

	h263ps_step u_step (
		.clk       (clk),
		.arst_n    (arst_n),
		.go        (go_s1),
		.data_byte (byte_s1),
		.last_byte (last_s1),
		.emit      (step_emit),
		.res       (step_res)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_free) begin
			out_valid_q <= go_s1 && step_emit;
		end
	end

	always_ff @(posedge clk) begin
		if (out_free && go_s1 && step_emit)
			res_q <= step_res;
	end

	assign out_valid = out_valid_q;
	assign status    = res_q.status;
	assign width     = res_q.width;
	assign height    = res_q.height;

`ifndef SYNTH
	a_result_source: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid_q) |-> $past(go_s1 && step_emit))
		else $error("result register loaded without a decision");

	a_stall_cause: assert property (@(posedge clk) disable iff (!arst_n)
		!in_ready |-> valid_s1 && step_emit && out_valid_q && !out_ready)
		else $error("input stalled with no pending result");

	a_fail_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && res_q.status == h263ps_pkg::STATUS_FAIL |->
		res_q.width == '0 && res_q.height == '0)
		else $error("failure result carries a size");
`endif

endmodule

>>> dv/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench - H.263 picture size parser check
// Feeds whole buffers (start code, PTYPE, PLUSPTYPE and CPFMT headers with
// random content, truncated buffers and noise) through the byte channel under
// random idling on both sides, and checks every reported size against a
// bit-serial parser model kept alongside, or a typed directed expectation.
// ----------------------------------------------------------------------------
module testbench;

	// Parser steps of the bit-serial model
	typedef enum logic [2:0] {
		SCAN_CODE,
		SCAN_HEAD,
		SCAN_UFEP,
		SCAN_OFMT,
		SCAN_PWI,
		SCAN_PHI,
		SCAN_DONE
	} scan_step_t;

	// One row of the directed table; want is used only where known is set
	typedef struct {
		logic                 data;
		logic                 last;
		logic                 known;
		h263ps_pkg::pic_res_t want;
	} stim_row_dummy_t;

	typedef struct {
		logic [7:0]           data;
		logic                 last;
		logic                 known;
		h263ps_pkg::pic_res_t want;
	} stim_row_t;

	localparam logic [21:0] PSC_CODE  = 22'h000020;
	localparam logic [5:0]  PSC_BITS  = 6'd22;
	localparam logic [5:0]  HEAD_BITS = 6'd16;  // 8 TR + 5 flags + 3 format
	localparam logic [5:0]  UFEP_BITS = 6'd3;
	localparam logic [5:0]  OFMT_BITS = 6'd3;
	localparam logic [5:0]  PWI_LEAD  = 6'd38;  // OPPTYPE rest, MPPTYPE, CPM, PAR, PWI
	localparam logic [5:0]  PHI_BITS  = 6'd10;  // marker + PHI
	localparam int          END_WAIT  = 10;     // result path is two registers deep

	logic                            clk;
	logic                            arst_n    = 1'b0;
	logic                            in_valid  = 1'b0;
	logic                            in_ready;
	logic [7:0]                      data_byte = 8'h00;
	logic                            last_byte = 1'b0;
	logic                            out_valid;
	logic                            out_ready = 1'b0;
	logic                            status;
	logic [h263ps_pkg::WIDTH_W-1:0]  width;
	logic [h263ps_pkg::HEIGHT_W-1:0] height;

	h263_picture_size_parser_unit dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.data_byte (data_byte),
		.last_byte (last_byte),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.status    (status),
		.width     (width),
		.height    (height)
	);

	// Model state: shift window, current step, bit countdown and latched fields
	logic [31:0]          win_bits;
	scan_step_t           scan_at;
	logic [5:0]           bits_left;
	logic [2:0]           pic_fmt;
	logic [2:0]           ufep_val;
	logic [8:0]           pwi_val;
	logic                 size_given;
	h263ps_pkg::pic_res_t size_held;

	// Sizes still owed by the block, oldest first
	h263ps_pkg::pic_res_t sizes_due[$];
	stim_row_t            directed_rows[$];

	int src_idle_pct  = 0;
	int sink_idle_pct = 0;
	int mismatches    = 0;
	int bytes_sent    = 0;
	int buffers_sent  = 0;
	int sizes_checked = 0;
	int fails_seen    = 0;

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// Generous ceiling: the slowest legal run is well under a tenth of this
	initial begin
		#5ms;
		$display("Simulation FAILED");
		$finish;
	end

	// ------------------------------------------------------------------
	// Bit-serial parser model
	// ------------------------------------------------------------------
	task automatic clear_parse();
		win_bits   = '0;
		scan_at    = SCAN_CODE;
		bits_left  = '0;
		pic_fmt    = '0;
		ufep_val   = '0;
		pwi_val    = '0;
		size_given = 1'b0;
		size_held  = h263ps_pkg::RES_FAIL;
	endtask

	task automatic give_size(input h263ps_pkg::pic_res_t r);
		size_held  = r;
		size_given = 1'b1;
		scan_at    = SCAN_DONE;
	endtask

	// Standard source formats; 6 and 7 never get here as valid sizes
	function automatic h263ps_pkg::pic_res_t format_dims(input logic [2:0] fmt);
		h263ps_pkg::pic_res_t r;
		r = h263ps_pkg::RES_FAIL;
		case (fmt)
			h263ps_pkg::FMT_FORBIDDEN:
				r = '{status: h263ps_pkg::STATUS_OK, width: 12'd0, height: 11'd0};
			h263ps_pkg::FMT_SQCIF:
				r = '{status: h263ps_pkg::STATUS_OK, width: 12'd128, height: 11'd96};
			h263ps_pkg::FMT_QCIF:
				r = '{status: h263ps_pkg::STATUS_OK, width: 12'd176, height: 11'd144};
			h263ps_pkg::FMT_CIF:
				r = '{status: h263ps_pkg::STATUS_OK, width: 12'd352, height: 11'd288};
			h263ps_pkg::FMT_4CIF:
				r = '{status: h263ps_pkg::STATUS_OK, width: 12'd704, height: 11'd576};
			h263ps_pkg::FMT_16CIF:
				r = '{status: h263ps_pkg::STATUS_OK, width: 12'd1408, height: 11'd1152};
			default:
				r = h263ps_pkg::RES_FAIL;
		endcase
		return r;
	endfunction

	// A header field has just been completed in the low bits of the window
	task automatic field_complete();
		case (scan_at)
			SCAN_HEAD: begin
				pic_fmt = win_bits[2:0];
				if (pic_fmt >= h263ps_pkg::FMT_CUSTOM) begin
					scan_at   = SCAN_UFEP;
					bits_left = UFEP_BITS;
				end else begin
					give_size(format_dims(pic_fmt));
				end
			end
			SCAN_UFEP: begin
				ufep_val = win_bits[2:0];
				if (ufep_val != h263ps_pkg::UFEP_FULL) begin
					give_size(h263ps_pkg::RES_FAIL);
				end else begin
					scan_at   = SCAN_OFMT;
					bits_left = OFMT_BITS;
				end
			end
			SCAN_OFMT: begin
				pic_fmt = win_bits[2:0];
				if (pic_fmt == h263ps_pkg::FMT_EXTENDED) begin
					give_size(h263ps_pkg::RES_FAIL);
				end else if (pic_fmt == h263ps_pkg::FMT_CUSTOM) begin
					scan_at   = SCAN_PWI;
					bits_left = PWI_LEAD;
				end else begin
					give_size(format_dims(pic_fmt));
				end
			end
			SCAN_PWI: begin
				pwi_val   = win_bits[8:0];
				scan_at   = SCAN_PHI;
				bits_left = PHI_BITS;
			end
			SCAN_PHI: begin
				// marker bit ahead of PHI is not checked
				give_size('{status: h263ps_pkg::STATUS_OK,
					width:  ({3'b000, pwi_val} + 12'd1) << 2,
					height: {win_bits[8:0], 2'b00}});
			end
			default: begin
				give_size(h263ps_pkg::RES_FAIL);
			end
		endcase
	endtask

	// One byte through the model, MSB first; hit is set when it yields a size
	task automatic predict_byte(input logic [7:0] b, input logic last,
			output logic hit, output h263ps_pkg::pic_res_t r);
		logic had;
		int   i;
		had = size_given;
		hit = 1'b0;
		r   = h263ps_pkg::RES_FAIL;
		for (i = 0; i < 8 && !size_given; i++) begin
			win_bits = {win_bits[30:0], b[7-i]};
			if (scan_at == SCAN_CODE) begin
				if (bits_left < PSC_BITS)
					bits_left = bits_left + 6'd1;
				// byte aligned: the code's last bit is bit 2 of a byte
				if (i == 5 && bits_left >= PSC_BITS && win_bits[21:0] == PSC_CODE) begin
					scan_at   = SCAN_HEAD;
					bits_left = HEAD_BITS;
				end
			end else begin
				if (bits_left != 6'd0)
					bits_left = bits_left - 6'd1;
				if (bits_left == 6'd0)
					field_complete();
			end
		end
		// buffer ran out before any decision
		if (!had && !size_given && last)
			give_size(h263ps_pkg::RES_FAIL);
		if (!had && size_given) begin
			hit = 1'b1;
			r   = size_held;
		end
		if (last)
			clear_parse();
	endtask

	// ------------------------------------------------------------------
	// Sender side
	// ------------------------------------------------------------------
	// Offers one byte, waits for its transfer, then records what it owes.
	// A typed expectation from the directed table replaces the model's.
	task automatic send_byte(input logic [7:0] b, input logic last,
			input logic known, input h263ps_pkg::pic_res_t typed);
		logic                 hit;
		h263ps_pkg::pic_res_t r;
		while ($urandom_range(99) < src_idle_pct) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid  <= 1'b1;
		data_byte <= b;
		last_byte <= last;
		@(posedge clk);
		while (!in_ready)
			@(posedge clk);
		predict_byte(b, last, hit, r);
		if (known)
			sizes_due.push_back(typed);
		else if (hit)
			sizes_due.push_back(r);
		bytes_sent++;
		if (last)
			buffers_sent++;
	endtask

	// Random buffer: mostly a well-formed picture header with random field
	// content behind a short random prefix; some are cut short, some noise.
	task automatic send_random_buffer();
		logic [7:0] frame[$];
		logic [7:0] hdr[13];
		logic [2:0] fmt;
		logic [2:0] ufep;
		logic [2:0] ofmt;
		int         n;
		int         k;
		int         cut;
		if ($urandom_range(9) == 0) begin
			n = $urandom_range(1, 8);
			for (k = 0; k < n; k++)
				frame.push_back(8'($urandom_range(255)));
		end else begin
			n = $urandom_range(0, 3);
			for (k = 0; k < n; k++)
				frame.push_back(8'($urandom_range(255)));
			for (k = 0; k < 13; k++)
				hdr[k] = 8'($urandom_range(255));
			// start code: two zero bytes, then 100000 in the top six bits
			hdr[0]      = 8'h00;
			hdr[1]      = 8'h00;
			hdr[2][7:2] = 6'b100000;
			fmt         = 3'($urandom_range(7));
			hdr[4][4:2] = fmt;
			ufep        = ($urandom_range(3) != 0) ? h263ps_pkg::UFEP_FULL :
				3'($urandom_range(7));
			hdr[4][1:0] = ufep[2:1];
			hdr[5][7]   = ufep[0];
			ofmt        = ($urandom_range(1) != 0) ? h263ps_pkg::FMT_CUSTOM :
				3'($urandom_range(7));
			hdr[5][6:4] = ofmt;
			// PWI sits in hdr[9..10], PHI in hdr[10..11]: push both to the ends
			case ($urandom_range(3))
				0: begin
					hdr[9]  = 8'h00;
					hdr[10] = 8'h00;
					hdr[11] = 8'h00;
				end
				1: begin
					hdr[9]  = 8'hFF;
					hdr[10] = 8'hFF;
					hdr[11] = 8'hFF;
				end
				default: begin
				end
			endcase
			for (k = 0; k < 13; k++)
				frame.push_back(hdr[k]);
			n = $urandom_range(0, 2);
			for (k = 0; k < n; k++)
				frame.push_back(8'($urandom_range(255)));
			if ($urandom_range(5) == 0) begin
				cut = $urandom_range(1, frame.size());
				while (frame.size() > cut)
					void'(frame.pop_back());
			end
		end
		for (k = 0; k < frame.size(); k++)
			send_byte(frame[k], k == frame.size() - 1, 1'b0, h263ps_pkg::RES_FAIL);
	endtask

	// Drop valid and hold off until the block owes nothing
	task automatic drain_sizes();
		in_valid <= 1'b0;
		@(posedge clk);
		while (sizes_due.size() != 0)
			@(posedge clk);
	endtask

	function automatic stim_row_t row(input logic [7:0] data, input logic last,
			input logic known, input h263ps_pkg::pic_res_t want);
		stim_row_t s;
		s.data  = data;
		s.last  = last;
		s.known = known;
		s.want  = want;
		return s;
	endfunction

	// ------------------------------------------------------------------
	// Receiver side: random stalls, and every transfer checked in order
	// ------------------------------------------------------------------
	initial begin
		h263ps_pkg::pic_res_t want;
		h263ps_pkg::pic_res_t got;
		forever begin
			@(posedge clk);
			if (arst_n && out_valid && out_ready) begin
				got = '{status: status, width: width, height: height};
				if (sizes_due.size() == 0) begin
					mismatches++;
					if (mismatches <= 10)
						$display("%0t: transfer with none pending: status %0d %0dx%0d",
							$realtime, got.status, got.width, got.height);
				end else begin
					want = sizes_due.pop_front();
					sizes_checked++;
					if (want.status == h263ps_pkg::STATUS_FAIL)
						fails_seen++;
					if (got.status !== want.status || got.width !== want.width ||
							got.height !== want.height) begin
						mismatches++;
						if (mismatches <= 10)
							$display("%0t: expected %0d %0dx%0d, got %0d %0dx%0d",
								$realtime, want.status, want.width, want.height,
								got.status, got.width, got.height);
					end
				end
			end
			out_ready <= ($urandom_range(99) >= sink_idle_pct);
		end
	end

	// ------------------------------------------------------------------
	// Stimulus
	// ------------------------------------------------------------------
	initial begin
		int k;
		int stage;
		clear_parse();

		// Directed buffers, each closed by its last byte:
		//   lone start-code tail after reset (too few bits seen) -> failure
		//   16CIF with every spare bit set, decided on the last byte
		//   custom format with PWI and PHI all ones -> largest size
		//   buffer cut before the format -> failure
		//   extended PTYPE with the reserved OPPTYPE format -> failure
		directed_rows.push_back(row(8'h80, 1'b1, 1'b1, h263ps_pkg::RES_FAIL));

		directed_rows.push_back(row(8'h00, 1'b0, 1'b0, h263ps_pkg::RES_FAIL));
		directed_rows.push_back(row(8'h00, 1'b0, 1'b0, h263ps_pkg::RES_FAIL));
		directed_rows.push_back(row(8'h83, 1'b0, 1'b0, h263ps_pkg::RES_FAIL));
		directed_rows.push_back(row(8'hFF, 1'b0, 1'b0, h263ps_pkg::RES_FAIL));
		directed_rows.push_back(row(8'hF7, 1'b1, 1'b1,
			'{status: h263ps_pkg::STATUS_OK, width: 12'd1408, height: 11'd1152}));

		directed_rows.push_back(row(8'h00, 1'b0, 1'b0, h263ps_pkg::RES_FAIL));
		directed_rows.push_back(row(8'h00, 1'b0, 1'b0, h263ps_pkg::RES_FAIL));
		directed_rows.push_back(row(8'h80, 1'b0, 1'b0, h263ps_pkg::RES_FAIL));
		directed_rows.push_back(row(8'h00, 1'b0, 1'b0, h263ps_pkg::RES_FAIL));
		directed_rows.push_back(row(8'h1C, 1'b0, 1'b0, h263ps_pkg::RES_FAIL));
		directed_rows.push_back(row(8'hE0, 1'b0, 1'b0, h263ps_pkg::RES_FAIL));
		directed_rows.push_back(row(8'h00, 1'b0, 1'b0, h263ps_pkg::RES_FAIL));
		directed_rows.push_back(row(8'h00, 1'b0, 1'b0, h263ps_pkg::RES_FAIL));
		directed_rows.push_back(row(8'h00, 1'b0, 1'b0, h263ps_pkg::RES_FAIL));
		directed_rows.push_back(row(8'h7F, 1'b0, 1'b0, h263ps_pkg::RES_FAIL));
		directed_rows.push_back(row(8'hFF, 1'b0, 1'b0, h263ps_pkg::RES_FAIL));
		directed_rows.push_back(row(8'hF0, 1'b1, 1'b1,
			'{status: h263ps_pkg::STATUS_OK, width: 12'd2048, height: 11'd2044}));

		directed_rows.push_back(row(8'h00, 1'b0, 1'b0, h263ps_pkg::RES_FAIL));
		directed_rows.push_back(row(8'h00, 1'b0, 1'b0, h263ps_pkg::RES_FAIL));
		directed_rows.push_back(row(8'h80, 1'b0, 1'b0, h263ps_pkg::RES_FAIL));
		directed_rows.push_back(row(8'h00, 1'b1, 1'b1, h263ps_pkg::RES_FAIL));

		directed_rows.push_back(row(8'h00, 1'b0, 1'b0, h263ps_pkg::RES_FAIL));
		directed_rows.push_back(row(8'h00, 1'b0, 1'b0, h263ps_pkg::RES_FAIL));
		directed_rows.push_back(row(8'h80, 1'b0, 1'b0, h263ps_pkg::RES_FAIL));
		directed_rows.push_back(row(8'h00, 1'b0, 1'b0, h263ps_pkg::RES_FAIL));
		directed_rows.push_back(row(8'h1C, 1'b0, 1'b0, h263ps_pkg::RES_FAIL));
		directed_rows.push_back(row(8'hF0, 1'b1, 1'b1, h263ps_pkg::RES_FAIL));

		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		src_idle_pct  = 29;
		sink_idle_pct = 66;
		for (k = 0; k < directed_rows.size(); k++)
			send_byte(directed_rows[k].data, directed_rows[k].last,
				directed_rows[k].known, directed_rows[k].want);

		// Three random stages: receiver idles more, then sender, then neither.
		// Each stage ends with the sender held off until all sizes are in.
		for (stage = 0; stage < 3; stage++) begin
			case (stage)
				0: begin
					src_idle_pct  = 29;
					sink_idle_pct = 66;
				end
				1: begin
					src_idle_pct  = 66;
					sink_idle_pct = 29;
				end
				default: begin
					src_idle_pct  = 0;
					sink_idle_pct = 0;
				end
			endcase
			while (bytes_sent < 450 * (stage + 1) - 50 * stage)
				send_random_buffer();
			drain_sizes();
		end

		repeat (END_WAIT) @(posedge clk);

		$display("Covered %0d bytes in %0d buffers under mixed idling on both channels.",
			bytes_sent, buffers_sent);
		$display("Checked %0d sizes, %0d of them failures; %0d mismatches.",
			sizes_checked, fails_seen, mismatches);
		if (mismatches == 0) begin
			$display("Simulation PASSED");
		end else begin
			$display("Simulation FAILED");
		end
		$finish;
	end

endmodule

>>> h263_picture_size_parser_unit.f
rtl/core/h263ps_pkg.sv
rtl/core/h263ps_step.sv
rtl/core/h263_picture_size_parser_unit.sv
dv/testbench.sv
